@@ src/nsc_pkg.sv @@
package nsc_pkg;

	localparam int MAX_FRAME_LENGTH_DEF = 255;
	localparam int MIN_FRAME = 3;
	localparam int TDATA_W = 32;

	localparam logic [7:0] CH_LINE_FEED = 8'h0A;
	localparam logic [7:0] CH_CARRIAGE_RETURN = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

	typedef struct packed {
		logic       is_term;
		logic       is_dollar;
		logic       is_star;
		logic       is_hex;
		logic [3:0] hex_digit;
	} byte_class_t;

	typedef struct packed {
		logic [7:0] frame_length;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		logic       star_found;
		logic       frame_ok;
	} frame_result_t;

endpackage

@@ src/nmea_sentence_checksum_checker_core.sv @@
// NMEA 0183 sentence checksum checker.
// The slave stream carries one received character per beat in s_axis_tdata[7:0].
// CR, LF or '$' ends the current frame, and a '$' also opens the next one.
// Each ended frame of three or more bytes yields one beat on the master stream
// with the verdict, the computed XOR, the received hex checksum and the length.
// Shorter frames are dropped without a beat.
// Each accepted byte is held in an input register and processed once the result
// register is empty or is being taken; the result beat of a terminator is then presented from that register.
// One byte is accepted every cycle as long as the result register is empty or
// is being taken, so the sustained rate is one byte per clock cycle.
// When the receiver stalls with a result waiting, at most one more byte is
// taken into the input register, and only if it is empty; s_axis_tready then
// stays low until the result beat is accepted.
// Reset clears the frame state and both valid flags; the first byte after
// reset starts a new frame.
module nmea_sentence_checksum_checker_core
	import nsc_pkg::*;
#(
	parameter int MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata   // [0] frame_ok, [1] star_found,
	                                          // [9:2] computed_sum, [17:10] received_sum,
	                                          // [25:18] frame_length, rest zero
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          out_valid_q;
	frame_result_t out_res_q;
	logic          advance;
	logic          step;
	byte_class_t   cls;
	logic          res_valid;
	frame_result_t res;

	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step = valid_s1 && advance;

	nsc_byte_class u_class (
		.rx_byte (byte_s1),
		.cls     (cls)
	);

	nsc_frame_acc #(
		.MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cls       (cls),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(TDATA_W - $bits(frame_result_t))'(0), out_res_q};

endmodule

@@ src/nsc_byte_class.sv @@
module nsc_byte_class
	import nsc_pkg::*;
(
	input  logic [7:0]  rx_byte,
	output byte_class_t cls
);

	always_comb begin
		cls.is_term = (rx_byte == CH_LINE_FEED) || (rx_byte == CH_CARRIAGE_RETURN)
			|| (rx_byte == CH_DOLLAR);
		cls.is_dollar = (rx_byte == CH_DOLLAR);
		cls.is_star = (rx_byte == CH_STAR);
		cls.is_hex = 1'b1;
		cls.hex_digit = 4'd0;
		if (rx_byte inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			cls.hex_digit = 4'(rx_byte - CH_DIGIT_0);
		end else if (rx_byte inside {[CH_UPPER_A:CH_UPPER_F]}) begin
			cls.hex_digit = 4'(rx_byte - CH_UPPER_A + HEX_LETTER_BASE);
		end else if (rx_byte inside {[CH_LOWER_A:CH_LOWER_F]}) begin
			cls.hex_digit = 4'(rx_byte - CH_LOWER_A + HEX_LETTER_BASE);
		end else begin
			cls.is_hex = 1'b0;
		end
	end

endmodule

@@ src/nsc_frame_acc.sv @@
module nsc_frame_acc
	import nsc_pkg::*;
#(
	parameter int MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	input  byte_class_t   cls,
	output logic          res_valid,
	output frame_result_t res
);

	localparam int CW = $clog2(MAX_FRAME_LENGTH + 1);

	logic [CW-1:0] count_q, count_d, count_tk;
	logic [7:0]    xor_q, xor_d, xor_tk;
	logic          star_q, star_d, star_tk;
	logic          hex_act_q, hex_act_d, hex_act_tk;
	logic [7:0]    hex_q, hex_d, hex_tk;
	logic [CW-1:0] count_base;
	logic          first;

	// Frame state as seen by a byte that is not a terminator; a '$' starts from a cleared frame.
	always_comb begin
		count_base = cls.is_term ? '0 : count_q;
		first = (count_base == '0);
		count_tk = count_base;
		if (count_base < CW'(MAX_FRAME_LENGTH)) begin
			count_tk = count_base + CW'(1);
		end
		xor_tk = xor_q;
		star_tk = star_q;
		hex_act_tk = hex_act_q;
		hex_tk = hex_q;
		if (!first) begin
			if (!star_q) begin
				if (cls.is_star) begin
					star_tk = 1'b1;
					hex_act_tk = 1'b1;
				end else begin
					xor_tk = xor_q ^ rx_byte;
				end
			end else if (hex_act_q) begin
				if (cls.is_hex) begin
					hex_tk = {hex_q[3:0], cls.hex_digit};
				end else begin
					hex_act_tk = 1'b0;
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		xor_d = xor_q;
		star_d = star_q;
		hex_act_d = hex_act_q;
		hex_d = hex_q;
		if (cls.is_term && !cls.is_dollar) begin
			count_d = '0;
			xor_d = '0;
			star_d = 1'b0;
			hex_act_d = 1'b0;
			hex_d = '0;
		end else if (cls.is_dollar) begin
			count_d = count_tk;
			xor_d = '0;
			star_d = 1'b0;
			hex_act_d = 1'b0;
			hex_d = '0;
		end else begin
			count_d = count_tk;
			xor_d = xor_tk;
			star_d = star_tk;
			hex_act_d = hex_act_tk;
			hex_d = hex_tk;
		end
	end

	always_comb begin
		res_valid = step && cls.is_term && (32'(count_q) >= 32'(MIN_FRAME));
		res.frame_ok = star_q && (hex_q == xor_q);
		res.star_found = star_q;
		res.computed_sum = xor_q;
		res.received_sum = star_q ? hex_q : 8'd0;
		res.frame_length = (32'(count_q) > 32'd255) ? 8'hFF : 8'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xor_q <= '0;
			star_q <= 1'b0;
			hex_act_q <= 1'b0;
			hex_q <= '0;
		end else if (step) begin
			count_q <= count_d;
			xor_q <= xor_d;
			star_q <= star_d;
			hex_act_q <= hex_act_d;
			hex_q <= hex_d;
		end
	end

`ifndef SYNTHESIS
	a_hex_after_star: assert property (@(posedge clk) disable iff (!arst_n)
		hex_act_q |-> star_q) else $error("hex gathering without a star");
	a_empty_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (!star_q && xor_q == 8'd0 && hex_q == 8'd0))
		else $error("empty frame holds checksum state");
	a_ok_needs_star: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_ok |-> res.star_found) else $error("pass without a star");
	a_min_length: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.frame_length >= 8'(MIN_FRAME)) else $error("short frame reported");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(count_q)) else $error("frame count moved without a beat");
`endif

endmodule
